// ----- design/urldec_pkg.sv -----
`default_nettype none

package urldec_pkg;

   // width of the decoded byte counter
   localparam int LENGTH_BITS = 16;
   // compare width that holds both the counter and the 16-bit capacity
   localparam int CMP_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [CMP_W-1:0] TOTAL_MAX = CMP_W'(16'hFFFF);

   // results one input byte can cause: two held bytes, the byte, the terminator
   localparam int MAX_RESULTS = 4;
   localparam int CAPACITY_RESET = 256;

   // register indexes
   typedef enum logic {
      REG_OUT_CAPACITY = 1'b0,
      REG_UNUSED       = 1'b1
   } reg_index_type;

   // character codes
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CASE_BIT   = 8'h20;
   localparam logic [7:0] HEX_TEN    = 8'd10;

   typedef logic [LENGTH_BITS-1:0] len_type;

   // one result
   typedef struct packed {
      logic [15:0] total_length;
      logic        is_end;
      logic        fits;
      logic [7:0]  out_byte;
   } rsp_item_type;

   // counter step for one decoded byte
   typedef struct packed {
      len_type count;
      logic    fits;
   } emit_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c inside {[CH_ZERO:CH_NINE], [CH_LOWER_A:CH_LOWER_F],
                          [CH_UPPER_A:CH_UPPER_F]});
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
         v = c - CH_ZERO;
      end else begin
         v = (c | CASE_BIT) - CH_LOWER_A + HEX_TEN;
      end
      hex_val = v[3:0];
   endfunction

   // saturating count of a decoded byte and its fit against the capacity
   function automatic emit_type emit_step(input len_type cnt, input logic [15:0] cap);
      emit_type r;
      if (cnt == LEN_MAX) begin
         r.count = cnt;
         r.fits  = 1'b0;
      end else begin
         r.count = cnt + 1'b1;
         r.fits  = CMP_W'(r.count) < CMP_W'(cap);
      end
      emit_step = r;
   endfunction

endpackage

`default_nettype wire

// ----- design/url_percent_decoder.sv -----
`default_nettype none

// URL percent decoder. Bytes of an encoded string enter on req (tlast marks
// the final byte) and decoded bytes leave on rsp: '+' becomes a space, '%'
// with two hex digits becomes the byte they name, and anything else, a
// stray '%' included, passes unchanged. A '%' and its first digit are held
// back until the next byte decides them; at end of string every held byte
// is sent literally, then a terminator transaction (tlast high, byte 0)
// that carries the decoded length plus one, saturating. tuser flags whether
// a byte's position lies below out_capacity. Timing: a byte is held in the
// input register and its results are loaded into the output buffer once
// that buffer is empty or its last result is being taken; the block takes
// one byte per cycle while each byte gives at most one result and the
// output is not stalled. A byte that gives several results (up to four)
// holds the output buffer until its last result is taken; the next byte waits.
module url_percent_decoder
   import urldec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input byte stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,   // last_byte
   // decoded stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_byte, [23:8] total_length
   output logic             rsp_tuser,   // fits
   output logic             rsp_tlast,   // is_end
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   typedef enum logic [1:0] {
      PH_NONE    = 2'd0,
      PH_PERCENT = 2'd1,
      PH_DIGIT   = 2'd2
   } phase_type;

   // register port
   logic [15:0] capacity_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 16'(CAPACITY_RESET);
      end else if (csr_write && reg_index_type'(csr_paddr[2]) == REG_OUT_CAPACITY) begin
         capacity_ff <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[2]))
         REG_OUT_CAPACITY: csr_prdata = {16'b0, capacity_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       load;

   assign req_tready = !in_valid_ff || load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // decoder state
   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   len_type    count_ff, count_in;

   // output buffer
   rsp_item_type burst_ff [MAX_RESULTS];
   rsp_item_type burst_in [MAX_RESULTS];
   logic [2:0]   burst_cnt_ff, burst_cnt_in;
   logic         rsp_fire;

   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign load     = in_valid_ff &&
                     (burst_cnt_ff == 3'd0 || (burst_cnt_ff == 3'd1 && rsp_fire));

   // decode one byte into up to three data bytes and an optional terminator
   logic [7:0] data_byte [3];
   logic [1:0] data_num;
   logic       plain_go;
   emit_type   step [3];
   len_type    run_count;

   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      data_byte = '{default: '0};
      data_num  = 2'd0;
      plain_go  = 1'b0;

      // handle held bytes first
      case (phase_ff)
         PH_NONE: begin
            plain_go = 1'b1;
         end
         PH_PERCENT: begin
            if (is_hex(in_byte_ff) && !in_last_ff) begin
               held_in  = in_byte_ff;
               phase_in = PH_DIGIT;
            end else begin
               phase_in     = PH_NONE;
               data_byte[0] = CH_PERCENT;
               data_num     = 2'd1;
               plain_go     = 1'b1;
            end
         end
         PH_DIGIT: begin
            phase_in = PH_NONE;
            held_in  = '0;
            if (is_hex(in_byte_ff)) begin
               data_byte[0] = {hex_val(held_ff), hex_val(in_byte_ff)};
               data_num     = 2'd1;
            end else begin
               data_byte[0] = CH_PERCENT;
               data_byte[1] = held_ff;
               data_num     = 2'd2;
               plain_go     = 1'b1;
            end
         end
         default: begin
            phase_in = PH_NONE;
            plain_go = 1'b1;
         end
      endcase

      // the byte itself with nothing held
      if (plain_go) begin
         if (in_byte_ff == CH_PLUS) begin
            data_byte[data_num] = CH_SPACE;
            data_num            = data_num + 2'd1;
         end else if (in_byte_ff == CH_PERCENT && !in_last_ff) begin
            phase_in = PH_PERCENT;
         end else begin
            data_byte[data_num] = in_byte_ff;
            data_num            = data_num + 2'd1;
         end
      end
   end

   // count the data bytes and build the results
   always_comb begin
      burst_in  = '{default: '0};
      run_count = count_ff;
      for (int i = 0; i < 3; i++) begin
         step[i] = emit_step(run_count, capacity_ff);
         if (2'(i) < data_num) begin
            run_count            = step[i].count;
            burst_in[i].out_byte = data_byte[i];
            burst_in[i].fits     = step[i].fits;
         end
      end

      burst_cnt_in = {1'b0, data_num};
      count_in     = run_count;

      // terminator after the data bytes
      if (in_last_ff) begin
         burst_in[data_num].is_end = 1'b1;
         burst_in[data_num].fits   = (run_count != LEN_MAX) &&
                                     (CMP_W'(run_count) < CMP_W'(capacity_ff));
         if (run_count == LEN_MAX) begin
            burst_in[data_num].total_length = 16'(run_count);
         end else if (CMP_W'(run_count) + CMP_W'(1) > TOTAL_MAX) begin
            burst_in[data_num].total_length = 16'hFFFF;
         end else begin
            burst_in[data_num].total_length = 16'(CMP_W'(run_count) + CMP_W'(1));
         end
         burst_cnt_in = burst_cnt_in + 3'd1;
         count_in     = '0;
      end
   end

   // decoder state and output buffer count
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NONE;
         held_ff      <= '0;
         count_ff     <= '0;
         burst_cnt_ff <= '0;
      end else begin
         if (load) begin
            phase_ff     <= in_last_ff ? PH_NONE : phase_in;
            held_ff      <= in_last_ff ? 8'd0 : held_in;
            count_ff     <= count_in;
            burst_cnt_ff <= burst_cnt_in;
         end else if (rsp_fire) begin
            burst_cnt_ff <= burst_cnt_ff - 3'd1;
         end
      end
   end

   // output buffer payload, shifted down as results leave
   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst_in;
      end else if (rsp_fire) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            burst_ff[i] <= burst_ff[i+1];
         end
      end
   end

   assign rsp_tvalid = (burst_cnt_ff != 3'd0);
   assign rsp_tdata  = {burst_ff[0].total_length, burst_ff[0].out_byte};
   assign rsp_tuser  = burst_ff[0].fits;
   assign rsp_tlast  = burst_ff[0].is_end;

   // checks
   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      burst_cnt_ff <= 3'(MAX_RESULTS))
      else $error("output buffer count out of range");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      load && in_last_ff |=> phase_ff == PH_NONE && count_ff == '0 && held_ff == '0)
      else $error("decoder state not cleared after end of string");

   a_held_hex: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DIGIT |-> is_hex(held_ff))
      else $error("held digit is not hex");

   a_data_no_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[23:8] == 16'd0)
      else $error("data transaction carries a length");

   a_end_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:0] == 8'd0 && rsp_tdata[23:8] != 16'd0)
      else $error("malformed terminator transaction");

endmodule

`default_nettype wire

// ----- verif/tb_url_percent_decoder.sv -----
module tb_url_percent_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import urldec_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 10_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_STRING_BYTES = 24;

   // what the decoder holds back between bytes
   localparam logic [1:0] HOLD_NONE    = 2'd0;
   localparam logic [1:0] HOLD_PERCENT = 2'd1;
   localparam logic [1:0] HOLD_DIGIT   = 2'd2;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   url_percent_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // decoder state mirrored by the testbench
   logic [1:0]    dec_phase = HOLD_NONE;
   logic [7:0]    dec_held = '0;
   len_type       dec_count = '0;
   logic [15:0]   dec_capacity = 16'(CAPACITY_RESET);

   byte_item_type pending_bytes[$];
   rsp_item_type  expected_chars[$];
   int            mismatch_count = 0;
   int unsigned   cycle_count = 0;
   bit            idling_on = 1'b1;
   bit            req_taken = 1'b0;
   int            req_gap = 0;
   int            rsp_stall = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
      mismatch_count++;
   endtask

   function automatic logic is_hex_char(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
             (c >= CH_LOWER_A && c <= CH_LOWER_F);
   endfunction

   // letters carry their value minus nine in the low nibble
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c <= CH_NINE) begin
         return c[3:0];
      end
      return c[3:0] + 4'd9;
   endfunction

   // one decoded byte: count it, saturating, and check it against the capacity
   task automatic push_char(input logic [7:0] b);
      rsp_item_type e;
      e.out_byte = b;
      e.is_end = 1'b0;
      e.total_length = '0;
      if (dec_count == LEN_MAX) begin
         e.fits = 1'b0;
      end else begin
         dec_count = dec_count + 1'b1;
         e.fits = 32'(dec_count) < 32'(dec_capacity);
      end
      expected_chars.push_back(e);
   endtask

   // a byte with nothing held
   task automatic push_plain(input logic [7:0] b, input logic last);
      if (b == CH_PLUS) begin
         push_char(CH_SPACE);
      end else if (b == CH_PERCENT && !last) begin
         dec_phase = HOLD_PERCENT;
      end else begin
         push_char(b);
      end
   endtask

   // terminator carries length plus one, then the string state clears
   task automatic push_terminator();
      rsp_item_type e;
      longint total;
      total = longint'(dec_count) + 1;
      if (total > longint'(LEN_MAX)) total = longint'(LEN_MAX);
      if (total > 65535) total = 65535;
      e.out_byte = '0;
      e.is_end = 1'b1;
      e.total_length = 16'(total);
      e.fits = (dec_count != LEN_MAX) && (32'(dec_count) < 32'(dec_capacity));
      expected_chars.push_back(e);
      dec_count = '0;
      dec_phase = HOLD_NONE;
      dec_held = '0;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      case (dec_phase)
         HOLD_PERCENT: begin
            if (is_hex_char(b) && !last) begin
               dec_held = b;
               dec_phase = HOLD_DIGIT;
            end else begin
               dec_phase = HOLD_NONE;
               push_char(CH_PERCENT);
               push_plain(b, last);
            end
         end
         HOLD_DIGIT: begin
            dec_phase = HOLD_NONE;
            if (is_hex_char(b)) begin
               push_char({nibble_of(dec_held), nibble_of(b)});
            end else begin
               push_char(CH_PERCENT);
               push_char(dec_held);
               push_plain(b, last);
            end
            dec_held = '0;
         end
         default: begin
            dec_phase = HOLD_NONE;
            push_plain(b, last);
         end
      endcase
      if (last) push_terminator();
   endtask

   // input driver: one byte transaction at a time, with random gaps
   always @(negedge clock) begin : req_driver
      logic v;
      byte_item_type it;
      v = req_tvalid;
      if (req_taken) begin
         v = 1'b0;
         req_taken = 1'b0;
      end
      if (!reset && !v) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_bytes.size() > 0) begin
            if (idling_on && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 6);
            end else begin
               it = pending_bytes.pop_front();
               req_tdata <= it.data;
               req_tlast <= it.last;
               v = 1'b1;
            end
         end
      end
      req_tvalid <= v;
   end

   // result side backpressure in bursts
   always @(negedge clock) begin : rsp_receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // predict on accepted bytes, check accepted results in order
   always @(posedge clock) begin : stream_monitor
      rsp_item_type e;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("unexpected result transaction", 32'(rsp_tdata), 32'd0);
            end else begin
               e = expected_chars.pop_front();
               if (rsp_tdata[7:0] !== e.out_byte)
                  report_mismatch("out_byte", 32'(rsp_tdata[7:0]), 32'(e.out_byte));
               if (rsp_tuser !== e.fits)
                  report_mismatch("fits", 32'(rsp_tuser), 32'(e.fits));
               if (rsp_tlast !== e.is_end)
                  report_mismatch("is_end", 32'(rsp_tlast), 32'(e.is_end));
               if (rsp_tdata[23:8] !== e.total_length)
                  report_mismatch("total_length", 32'(rsp_tdata[23:8]),
                                  32'(e.total_length));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_OUT_CAPACITY) dec_capacity = value;
   endtask

   task automatic csr_check_capacity();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {REG_OUT_CAPACITY, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[15:0] !== dec_capacity)
         report_mismatch("out_capacity readback", 32'(csr_prdata[15:0]),
                         32'(dec_capacity));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_text(input string s, input bit last_at_end);
      byte_item_type it;
      for (int i = 0; i < s.len(); i++) begin
         it.data = s[i];
         it.last = last_at_end && (i == s.len() - 1);
         pending_bytes.push_back(it);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      byte_item_type it;
      it.data = b;
      it.last = last;
      pending_bytes.push_back(it);
   endtask

   // hold off until every byte is taken and every result has arrived
   task automatic wait_all_results();
      while (pending_bytes.size() > 0 || req_tvalid || expected_chars.size() > 0)
         @(posedge clock);
   endtask

   // idle point for a register write: drained plus the pipeline latency
   task automatic wait_idle();
      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] random_hex_char();
      logic [3:0] n;
      n = 4'($urandom_range(0, 15));
      if (n < 10) return CH_ZERO + 8'(n);
      if ($urandom_range(0, 1)) return CH_LOWER_A + 8'(n - 10);
      return CH_UPPER_A + 8'(n - 10);
   endfunction

   function automatic logic [7:0] random_non_hex();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (is_hex_char(c)) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   // well-formed escapes as the commonest token, with plus signs, raw bytes and broken escapes
   task automatic send_random_string(output int count);
      byte_item_type str[$];
      byte_item_type it;
      int tokens;
      int pick;
      tokens = $urandom_range(1, 12);
      it.last = 1'b0;
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            it.data = CH_PERCENT;          str.push_back(it);
            it.data = random_hex_char();   str.push_back(it);
            it.data = random_hex_char();   str.push_back(it);
         end else if (pick < 55) begin
            it.data = CH_PLUS;             str.push_back(it);
         end else if (pick < 75) begin
            it.data = 8'($urandom_range(0, 255)); str.push_back(it);
         end else if (pick < 85) begin
            it.data = CH_PERCENT;          str.push_back(it);
            it.data = random_non_hex();    str.push_back(it);
         end else if (pick < 95) begin
            it.data = CH_PERCENT;          str.push_back(it);
            it.data = random_hex_char();   str.push_back(it);
            it.data = random_non_hex();    str.push_back(it);
         end else begin
            it.data = CH_PERCENT;          str.push_back(it);
         end
      end
      str[$].last = 1'b1;
      count = str.size();
      foreach (str[i]) pending_bytes.push_back(str[i]);
   endtask

   task automatic random_phase(input int n_bytes);
      int added;
      int n;
      added = 0;
      while (added < n_bytes) begin
         send_random_string(n);
         added += n;
      end
   endtask

   initial begin : stimulus
      logic [15:0] cap;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: decodes, plus, mismatches, extremes, pending at end
      csr_check_capacity();
      send_text("%41+%aF%z%4g", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("%%47", 1'b1);
      // hold a percent and a digit across a full drain of results
      send_text("%4", 1'b0);
      wait_all_results();
      send_text("1", 1'b1);
      send_text("%4", 1'b1);
      send_text("%4x", 1'b1);
      send_text("%", 1'b1);
      send_text("+", 1'b1);
      wait_idle();

      // smallest capacity, then zero capacity
      csr_write(REG_OUT_CAPACITY, 16'd1);
      csr_check_capacity();
      send_text("ab", 1'b1);
      send_text("+", 1'b1);
      wait_idle();
      csr_write(REG_OUT_CAPACITY, 16'd0);
      send_text("a%41", 1'b1);
      wait_idle();

      // largest capacity with a string of random raw bytes
      csr_write(REG_OUT_CAPACITY, 16'hFFFF);
      csr_check_capacity();
      for (int i = 0; i < LONG_STRING_BYTES; i++)
         send_byte(8'($urandom_range(0, 255)), i == LONG_STRING_BYTES - 1);
      wait_idle();

      // writes to the unused index leave the capacity alone
      csr_write(REG_UNUSED, 16'($urandom_range(0, 65535)));
      csr_check_capacity();

      // random strings over several capacities
      cap = 16'($urandom_range(2, 20));
      csr_write(REG_OUT_CAPACITY, cap);
      random_phase(80);
      wait_idle();
      csr_write(REG_OUT_CAPACITY, 16'hFFFF);
      random_phase(60);
      wait_idle();
      csr_write(REG_OUT_CAPACITY, 16'd1);
      random_phase(50);
      wait_idle();
      cap = 16'($urandom_range(1, 65535));
      csr_write(REG_OUT_CAPACITY, cap);
      csr_check_capacity();
      random_phase(60);
      wait_idle();

      // closing stretch at full rate on both sides
      idling_on = 1'b0;
      csr_write(REG_OUT_CAPACITY, 16'(CAPACITY_RESET));
      random_phase(70);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- url_percent_decoder.f -----
design/urldec_pkg.sv
design/url_percent_decoder.sv
verif/tb_url_percent_decoder.sv
